// ===== src/rfrp_pkg.sv =====
// ----------------------------------------------------------------------------
// rfrp_pkg: shared types and constants of the frequency reply parser
// Frame marker bytes, window geometry and the decoder result type.
// ----------------------------------------------------------------------------
package rfrp_pkg;

  localparam int unsigned WIN_DEPTH  = 10;  // bytes held before the current one
  localparam int unsigned BCD_PAIRS  = 5;   // BCD bytes in a frequency reply
  localparam int unsigned FIRST_BCD  = 5;   // window entry of the least significant pair

  localparam logic [7:0] FRAME_START     = 8'hFE;
  localparam logic [7:0] FROM_CONTROLLER = 8'hE0;
  localparam logic [7:0] CMD_READ_FREQ   = 8'h03;
  localparam logic [7:0] FRAME_END       = 8'hFD;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] freq_t;

  // BCD bytes in decode order: the most significant pair sits in the top byte.
  typedef logic [BCD_PAIRS*8-1:0] bcd_word_t;

  typedef struct packed {
    freq_t frequency_hz;
    logic  bad_digit;
  } result_t;

endpackage

// ===== src/rfrp_in_if.sv =====
// ----------------------------------------------------------------------------
// rfrp_in_if: received byte channel
// Valid/ready channel carrying one serial byte and the restart flag.
// ----------------------------------------------------------------------------
interface rfrp_in_if;
  logic          valid;
  logic          ready;
  rfrp_pkg::byte_t rx_byte;
  logic          restart;

  modport source (output valid, output rx_byte, output restart, input ready);
  modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

// ===== src/rfrp_out_if.sv =====
// ----------------------------------------------------------------------------
// rfrp_out_if: decoded frequency channel
// Valid/ready channel carrying the frequency in hertz and the bad digit flag.
// ----------------------------------------------------------------------------
interface rfrp_out_if;
  logic          valid;
  logic          ready;
  rfrp_pkg::freq_t frequency_hz;
  logic          bad_digit;

  modport source (output valid, output frequency_hz, output bad_digit, input ready);
  modport sink   (input valid, input frequency_hz, input bad_digit, output ready);
endinterface

// ===== src/rfrp_cell.sv =====
// ----------------------------------------------------------------------------
// rfrp_cell: one stage of the byte window
// Holds one byte and its valid flag, and takes its neighbour's on each shift.
// ----------------------------------------------------------------------------
module rfrp_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  logic            clear,
  input  rfrp_pkg::byte_t data_in,
  input  logic            valid_in,
  output rfrp_pkg::byte_t data_out,
  output logic            valid_out
);

  rfrp_pkg::byte_t data_r;
  logic            valid_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      data_r <= data_in;
    end
  end

  // A cleared cell is refilled with an invalid byte from its neighbour.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= valid_in && !clear;
    end
  end

  assign data_out  = data_r;
  assign valid_out = valid_r;

endmodule

// ===== src/rfrp_decoder.sv =====
// ----------------------------------------------------------------------------
// rfrp_decoder: iterative BCD to binary converter
// One BCD pair per cycle: acc = acc*100 + hi*10 + lo, modulo 2^32.
// ----------------------------------------------------------------------------
module rfrp_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rfrp_pkg::bcd_word_t bcd_in,
  output logic                idle,
  output logic                res_valid,
  input  logic                res_ready,
  output rfrp_pkg::result_t   res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int unsigned CNT_W = $clog2(rfrp_pkg::BCD_PAIRS);
  localparam int unsigned WORD_W = rfrp_pkg::BCD_PAIRS * 8;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  rfrp_pkg::bcd_word_t bcd_r, bcd_nxt;
  rfrp_pkg::freq_t     acc_r, acc_nxt;
  logic                bad_r, bad_nxt;

  logic [3:0]      hi;
  logic [3:0]      lo;
  logic [7:0]      pair_val;
  rfrp_pkg::freq_t scaled;

  // Non-decimal nibbles are taken at face value, so a pair can reach 165.
  assign hi       = bcd_r[WORD_W-1 -: 4];
  assign lo       = bcd_r[WORD_W-5 -: 4];
  assign pair_val = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
  assign scaled   = acc_r * 32'd100;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    bcd_nxt   = bcd_r;
    acc_nxt   = acc_r;
    bad_nxt   = bad_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
          bcd_nxt   = bcd_in;
          acc_nxt   = '0;
          bad_nxt   = 1'b0;
        end
      end
      ST_RUN: begin
        acc_nxt = scaled + {24'd0, pair_val};
        bad_nxt = bad_r || (hi > 4'd9) || (lo > 4'd9);
        bcd_nxt = {bcd_r[WORD_W-9:0], 8'h00};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(rfrp_pkg::BCD_PAIRS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    bcd_r <= bcd_nxt;
    acc_r <= acc_nxt;
    bad_r <= bad_nxt;
  end

  assign idle             = (state_r == ST_IDLE);
  assign res_valid        = (state_r == ST_DONE);
  assign res.frequency_hz = acc_r;
  assign res.bad_digit    = bad_r;

endmodule

// ===== src/radio_freq_reply_parser.sv =====
// ----------------------------------------------------------------------------
// radio_freq_reply_parser: frequency reply frame parser
// Watches received bytes for a read-frequency reply from the configured
// radio and reports the decoded frequency in hertz.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   in_ch     sink       rx_byte (8 bits), restart (1 bit)
//   out_ch    source     frequency_hz (32 bits), bad_digit (1 bit)
//   cfg_*     write      radio_address (8 bits), written when cfg_we is high
//
// An item that closes no frame is taken while the decoder is idle.
// A matching frame occupies the decoder while it takes the five BCD pairs, one
// per cycle, through its multiply-add, and while it hands the result to the
// output register; the next item is taken only once that hand-over is done.
// If the output register still holds an earlier result that the sink has not
// taken, the hand-over, and with it the input, waits.
// Reset is synchronous and active low; it empties the window and clears
// radio_address.
// ----------------------------------------------------------------------------
module radio_freq_reply_parser (
  input  logic              clk,
  input  logic              rst_n,
  rfrp_in_if.sink           in_ch,
  rfrp_out_if.source        out_ch,
  input  logic              cfg_we,
  input  rfrp_pkg::byte_t   cfg_data
);

  localparam int unsigned DEPTH = rfrp_pkg::WIN_DEPTH;

  // Expected sender address of the reply.
  rfrp_pkg::byte_t radio_address_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radio_address_r <= '0;
    end else if (cfg_we) begin
      radio_address_r <= cfg_data;
    end
  end

  // The window is a row of cells. Cell DEPTH-1 holds the newest byte and
  // feeds its neighbour, so cell 0 holds the oldest. Each cell keeps its own
  // valid flag, and since valid bits enter at the newest end, the oldest
  // cell's flag tells that the window is full.
  logic            in_fire;
  rfrp_pkg::byte_t win_data  [DEPTH];
  logic            win_valid [DEPTH];

  assign in_fire = in_ch.valid && in_ch.ready;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_newest
      // The current byte always enters as valid, even on a restart.
      rfrp_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (in_fire),
        .clear     (1'b0),
        .data_in   (in_ch.rx_byte),
        .valid_in  (1'b1),
        .data_out  (win_data[i]),
        .valid_out (win_valid[i])
      );
    end else begin : g_inner
      rfrp_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (in_fire),
        .clear     (in_ch.restart),
        .data_in   (win_data[i+1]),
        .valid_in  (win_valid[i+1]),
        .data_out  (win_data[i]),
        .valid_out (win_valid[i])
      );
    end
  end

  // A frame ends with the current byte. A restarting byte is kept out of the
  // match, so it can never close a frame.
  logic frame_hit;

  assign frame_hit = in_fire && !in_ch.restart && win_valid[0] &&
                     (in_ch.rx_byte == rfrp_pkg::FRAME_END) &&
                     (win_data[0] == rfrp_pkg::FRAME_START) &&
                     (win_data[1] == rfrp_pkg::FRAME_START) &&
                     (win_data[2] == rfrp_pkg::FROM_CONTROLLER) &&
                     (win_data[3] == radio_address_r) &&
                     (win_data[4] == rfrp_pkg::CMD_READ_FREQ);

  // The most significant pair is the newest window byte, so it leads.
  rfrp_pkg::bcd_word_t bcd_word;

  always_comb begin
    for (int k = 0; k < rfrp_pkg::BCD_PAIRS; k++) begin
      bcd_word[k*8 +: 8] = win_data[rfrp_pkg::FIRST_BCD + k];
    end
  end

  logic              dec_idle;
  logic              dec_valid;
  logic              dec_ready;
  rfrp_pkg::result_t dec_res;

  rfrp_decoder u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (frame_hit),
    .bcd_in    (bcd_word),
    .idle      (dec_idle),
    .res_valid (dec_valid),
    .res_ready (dec_ready),
    .res       (dec_res)
  );

  // Bytes are taken only while no frame is being decoded, so a hit always
  // finds the decoder free.
  assign in_ch.ready = dec_idle;

  // Output register between the decoder and the result channel.
  logic              out_valid_r;
  rfrp_pkg::result_t out_res_r;

  assign dec_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dec_ready) begin
      out_valid_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_ready && dec_valid) begin
      out_res_r <= dec_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frequency_hz = out_res_r.frequency_hz;
  assign out_ch.bad_digit    = out_res_r.bad_digit;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the frequency reply parser
// Streams received bytes into the parser, keeps its own copy of the byte window
// to work out which replies should be decoded, and checks every decoded item.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned FRAME_LEN     = 11;  // FE FE E0 addr 03 b0..b4 FD
  localparam int unsigned SETTLE_CYCLES = 16;  // quiet cycles after the last reply
  localparam int          NO_RESTART    = -1;

  typedef rfrp_pkg::byte_t frame_t [FRAME_LEN];

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  rfrp_pkg::byte_t cfg_data;

  rfrp_in_if  in_ch ();
  rfrp_out_if out_ch ();

  radio_freq_reply_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the parser state. Entry WIN_DEPTH-1 is the newest byte.
  rfrp_pkg::byte_t shadow_window [rfrp_pkg::WIN_DEPTH];
  int unsigned     shadow_fill;
  rfrp_pkg::byte_t shadow_address;

  // Decoded replies that the parser still owes us, oldest first.
  rfrp_pkg::result_t pending_replies [$];

  int unsigned bytes_sent;
  int unsigned replies_checked   = 0;
  int unsigned bad_digit_replies = 0;
  int unsigned fail_count        = 0;

  // Idling controls: the sender and the receiver stall only when enabled, so
  // each phase can run either with gaps or flat out.
  bit          in_gaps_on;
  bit          out_stalls_on;
  int          out_hold = 0;

  // Now and then a gap is long enough to let the decoder and the output register
  // fill up completely.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end else if (r < 93) begin
      return $urandom_range(3, 8);
    end
    return $urandom_range(20, 40);
  endfunction

  // Takes one accepted byte into the shadow window and queues the decoded
  // reply when the window, together with this byte, forms a complete frame.
  function automatic void track_byte(rfrp_pkg::byte_t b, logic restart);
    rfrp_pkg::freq_t hz;
    logic            bad;
    logic [3:0]      hi;
    logic [3:0]      lo;
    int              k;
    if (restart) begin
      for (k = 0; k < rfrp_pkg::WIN_DEPTH; k++) shadow_window[k] = '0;
      shadow_fill = 0;
    end
    if (shadow_fill >= rfrp_pkg::WIN_DEPTH && b == rfrp_pkg::FRAME_END &&
        shadow_window[0] == rfrp_pkg::FRAME_START &&
        shadow_window[1] == rfrp_pkg::FRAME_START &&
        shadow_window[2] == rfrp_pkg::FROM_CONTROLLER &&
        shadow_window[3] == shadow_address &&
        shadow_window[4] == rfrp_pkg::CMD_READ_FREQ) begin
      hz  = '0;
      bad = 1'b0;
      // Most significant pair first, so each step is a multiply by one hundred.
      for (k = int'(rfrp_pkg::WIN_DEPTH) - 1; k >= int'(rfrp_pkg::FIRST_BCD); k--) begin
        hi = shadow_window[k][7:4];
        lo = shadow_window[k][3:0];
        if (hi > 4'd9 || lo > 4'd9) bad = 1'b1;
        hz = hz * rfrp_pkg::freq_t'(100) + rfrp_pkg::freq_t'(hi) * rfrp_pkg::freq_t'(10) +
             rfrp_pkg::freq_t'(lo);
      end
      pending_replies.push_back(rfrp_pkg::result_t'{frequency_hz: hz, bad_digit: bad});
    end
    for (k = 0; k < int'(rfrp_pkg::WIN_DEPTH) - 1; k++) begin
      shadow_window[k] = shadow_window[k + 1];
    end
    shadow_window[rfrp_pkg::WIN_DEPTH - 1] = b;
    if (shadow_fill < rfrp_pkg::WIN_DEPTH) shadow_fill++;
  endfunction

  // Assembles a reply frame; the BCD word holds b4 in its top byte.
  function automatic frame_t make_reply(rfrp_pkg::byte_t addr, rfrp_pkg::bcd_word_t digits);
    frame_t f;
    int     i;
    f[0] = rfrp_pkg::FRAME_START;
    f[1] = rfrp_pkg::FRAME_START;
    f[2] = rfrp_pkg::FROM_CONTROLLER;
    f[3] = addr;
    f[4] = rfrp_pkg::CMD_READ_FREQ;
    for (i = 0; i < rfrp_pkg::BCD_PAIRS; i++) f[rfrp_pkg::FIRST_BCD + i] = digits[i*8 +: 8];
    f[FRAME_LEN - 1] = rfrp_pkg::FRAME_END;
    return f;
  endfunction

  // Mostly proper BCD pairs, with the odd byte of any value so that non-decimal
  // nibbles and the wrap of the sum beyond 32 bits both turn up.
  function automatic rfrp_pkg::bcd_word_t random_digits();
    rfrp_pkg::bcd_word_t w;
    int                  i;
    for (i = 0; i < rfrp_pkg::BCD_PAIRS; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        w[i*8 +: 8] = 8'($urandom_range(0, 255));
      end else begin
        w[i*8 +: 8] = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      end
    end
    return w;
  endfunction

  // Presents one item and holds it until the parser takes it. The caller is
  // always just past a rising edge, and valid is left high so that a following
  // item can go out back to back.
  task automatic send_byte(rfrp_pkg::byte_t b, logic restart);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.restart <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    track_byte(b, restart);
    bytes_sent++;
  endtask

  task automatic pace_sender();
    int n;
    if (in_gaps_on && $urandom_range(0, 2) == 0) begin
      n = pick_gap();
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_frame(frame_t f, int restart_at);
    int i;
    for (i = 0; i < FRAME_LEN; i++) begin
      send_byte(f[i], i == restart_at);
      pace_sender();
    end
  endtask

  // Stops sending and waits until every reply owed has been seen, then leaves
  // a short quiet spell before whatever comes next.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_address(rfrp_pkg::byte_t addr);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= addr;
    @(posedge clk);
    cfg_we         <= 1'b0;
    shadow_address  = addr;
  endtask

  // Straight after reset the address is zero. The first frame opens with a
  // restart, so it only completes on its eleventh byte, exactly when the window
  // first fills. It carries the largest decimal digits, whose sum wraps past
  // 32 bits; the second carries all-ones bytes, which must flag bad digits.
  task automatic test_frame_extremes();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    send_frame(make_reply(8'h00, {rfrp_pkg::BCD_PAIRS{8'h99}}), 0);
    send_frame(make_reply(8'h00, {rfrp_pkg::BCD_PAIRS{8'hFF}}), NO_RESTART);
    settle();
  endtask

  // One phase of random traffic under a given radio address. Most of it is
  // well-formed replies with random digits, so that the full compare and the
  // decoder are exercised; the rest are frames for another radio, frames with
  // a spoilt marker, frames cut by a restart, back-to-back replies that overlap,
  // bare headers and loose noise biased towards the marker values.
  task automatic test_random_traffic(rfrp_pkg::byte_t addr, bit gaps, bit stalls,
                                     int unsigned count);
    frame_t      f;
    int          r;
    int          pos;
    int          n;
    int          i;
    int unsigned stop_at;
    program_address(addr);
    in_gaps_on    = gaps;
    out_stalls_on = stalls;
    stop_at       = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_frame(make_reply(shadow_address, random_digits()),
                   ($urandom_range(0, 9) == 0) ? 0 : NO_RESTART);
      end else if (r < 63) begin
        send_frame(make_reply(shadow_address ^ 8'($urandom_range(1, 255)),
                              random_digits()), NO_RESTART);
      end else if (r < 71) begin
        f   = make_reply(shadow_address, random_digits());
        pos = $urandom_range(0, 5);
        if (pos == 5) pos = int'(FRAME_LEN) - 1;
        f[pos] = f[pos] ^ 8'($urandom_range(1, 255));
        send_frame(f, NO_RESTART);
      end else if (r < 77) begin
        // A restart anywhere after the first byte breaks the frame.
        send_frame(make_reply(shadow_address, random_digits()),
                   $urandom_range(1, FRAME_LEN - 1));
      end else if (r < 82) begin
        // The digits of the first reply spell a header, so its end marker
        // becomes the least significant pair of a second, overlapping reply.
        send_frame(make_reply(shadow_address,
                              {rfrp_pkg::CMD_READ_FREQ, shadow_address,
                               rfrp_pkg::FROM_CONTROLLER, rfrp_pkg::FRAME_START,
                               rfrp_pkg::FRAME_START}), NO_RESTART);
        for (i = 0; i < rfrp_pkg::BCD_PAIRS - 1; i++) begin
          send_byte(8'($urandom_range(0, 255)), 1'b0);
          pace_sender();
        end
        send_byte(rfrp_pkg::FRAME_END, 1'b0);
        pace_sender();
      end else if (r < 87) begin
        f = make_reply(shadow_address, random_digits());
        n = $urandom_range(1, FRAME_LEN - 2);
        for (i = 0; i < n; i++) begin
          send_byte(f[i], 1'b0);
          pace_sender();
        end
      end else begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 9))
            0: send_byte(rfrp_pkg::FRAME_START, $urandom_range(0, 19) == 0);
            1: send_byte(rfrp_pkg::FROM_CONTROLLER, $urandom_range(0, 19) == 0);
            2: send_byte(rfrp_pkg::CMD_READ_FREQ, $urandom_range(0, 19) == 0);
            3: send_byte(rfrp_pkg::FRAME_END, $urandom_range(0, 19) == 0);
            4: send_byte(shadow_address, $urandom_range(0, 19) == 0);
            default: send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
          endcase
          pace_sender();
        end
      end
      // Now and then the sender holds off until every reply is out.
      if ($urandom_range(0, 49) == 0) settle();
    end
  endtask

  // Receiver: ready drops for a random stretch now and then while stalls are on.
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_ch.ready <= 1'b0;
      out_hold      = out_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (out_stalls_on && $urandom_range(0, 3) == 0) out_hold = pick_gap();
    end
  end

  // Result check: each accepted item is compared with the oldest reply owed.
  always @(posedge clk) begin
    rfrp_pkg::result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual frequency_hz=%0d bad_digit=%0b",
                 $time, out_ch.frequency_hz, out_ch.bad_digit);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_ch.frequency_hz !== want.frequency_hz) begin
          $display("%0t: frequency_hz mismatch, expected %0d, actual %0d",
                   $time, want.frequency_hz, out_ch.frequency_hz);
          fail_count++;
        end
        if (out_ch.bad_digit !== want.bad_digit) begin
          $display("%0t: bad_digit mismatch, expected %0b, actual %0b",
                   $time, want.bad_digit, out_ch.bad_digit);
          fail_count++;
        end
        replies_checked++;
        if (want.bad_digit) bad_digit_replies++;
      end
    end
  end

  initial begin
    // Every input starts from a known value while reset is held.
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    in_ch.valid    = 1'b0;
    in_ch.rx_byte  = '0;
    in_ch.restart  = 1'b0;
    in_gaps_on     = 1'b0;
    out_stalls_on  = 1'b0;
    shadow_address = '0;
    shadow_fill    = 0;
    foreach (shadow_window[k]) shadow_window[k] = '0;
    bytes_sent     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_frame_extremes();
    test_random_traffic(8'hFF, 1'b0, 1'b0, 150);
    test_random_traffic(8'($urandom_range(0, 255)), 1'b1, 1'b1, 300);
    test_random_traffic(rfrp_pkg::FRAME_START, 1'b1, 1'b0, 250);
    test_random_traffic(rfrp_pkg::FROM_CONTROLLER, 1'b0, 1'b1, 250);
    test_random_traffic(rfrp_pkg::FRAME_END, 1'b1, 1'b1, 250);
    test_random_traffic(8'h00, 1'b1, 1'b1, 300);
    settle();

    $display("Summary: %0d bytes sent over seven phases and six radio addresses,",
             bytes_sent);
    $display("Summary: %0d decoded replies checked, %0d of them flagged with bad digits.",
             replies_checked, bad_digit_replies);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Safety net well beyond the slowest legal run.
  initial begin
    #15000000;
    $display("Timeout: the run did not complete in time.");
    $display("testbench: FAIL");
    $finish;
  end

endmodule
